FILE: rtl/efams_pkg.sv
// ----------------------------------------------------------------------------
// efams_pkg: shared types and constants for the floor/arrow matrix scan
// Glyph tables, motor mode codes and the structs passed between modules.
// ----------------------------------------------------------------------------
package efams_pkg;

  localparam int ROWS       = 8;
  localparam int ROW_W      = 3;
  localparam int TICK_W     = 32;
  localparam int PERIOD_W   = 16;

  localparam logic [PERIOD_W-1:0] PERIOD_RESET = 16'd200;

  // Motor mode codes carried by each tick
  typedef enum logic [1:0] {
    MODE_IDLE  = 2'd0,
    MODE_UP    = 2'd1,
    MODE_DOWN  = 2'd2,
    MODE_OTHER = 2'd3
  } mode_t;

  // Rotation direction of an arrow store
  typedef enum logic {
    DIR_UP   = 1'b0,
    DIR_DOWN = 1'b1
  } dir_t;

  // Digit glyphs "1".."4", row 0 first
  localparam logic [7:0] DIGIT_GLYPH [4][ROWS] = '{
    '{8'h18, 8'h38, 8'h18, 8'h18, 8'h18, 8'h18, 8'h7E, 8'h7E},
    '{8'h70, 8'h88, 8'h08, 8'h10, 8'h20, 8'h40, 8'hF8, 8'h06},
    '{8'hF8, 8'h10, 8'h20, 8'h10, 8'h08, 8'h88, 8'h70, 8'h06},
    '{8'h10, 8'h30, 8'h50, 8'h90, 8'hF8, 8'h10, 8'h10, 8'h06}
  };

  localparam logic [7:0] UP_GLYPH [ROWS] =
    '{8'h10, 8'h28, 8'h44, 8'hEE, 8'h28, 8'h28, 8'h38, 8'h28};
  localparam logic [7:0] DOWN_GLYPH [ROWS] =
    '{8'h28, 8'h38, 8'h28, 8'h28, 8'hEE, 8'h44, 8'h28, 8'h10};

  // Tick held in the input register
  typedef struct packed {
    logic       valid;
    mode_t      mode;
    logic [1:0] floor;
  } item_t;

  // Request to an arrow store for the tick being processed
  typedef struct packed {
    logic              valid;
    logic [ROW_W-1:0]  row;
    logic [TICK_W-1:0] now;
  } arrow_req_t;

  // One scanned row
  typedef struct packed {
    logic [7:0]       row_select_n;
    logic [7:0]       column_bits;
    logic [ROW_W-1:0] row_index;
    logic             frame_last;
  } result_t;

endpackage

FILE: rtl/efams_if.sv
// ----------------------------------------------------------------------------
// efams_if: channel interfaces
// Tick channel into the scan core and scanned-row channel out of it.
// ----------------------------------------------------------------------------
interface efams_tick_if;
  logic       valid;
  logic       ready;
  logic [1:0] motor_mode;
  logic [1:0] floor;

  modport source (output valid, motor_mode, floor, input ready);
  modport sink   (input valid, motor_mode, floor, output ready);
endinterface

interface efams_row_if;
  logic       valid;
  logic       ready;
  logic [7:0] row_select_n;
  logic [7:0] column_bits;
  logic [2:0] row_index;
  logic       frame_last;

  modport source (output valid, row_select_n, column_bits, row_index, frame_last,
                  input ready);
  modport sink   (input valid, row_select_n, column_bits, row_index, frame_last,
                  output ready);
endinterface

FILE: rtl/elevator_floor_arrow_matrix_scan_core.sv
// ----------------------------------------------------------------------------
// elevator_floor_arrow_matrix_scan_core: 8x8 indicator row-scan driver
// Per 1 ms tick, shows one matrix row of a floor digit or a rotating arrow (none in mode 3).
//
//   channel  dir  handshake    payload
//   tick     in   valid/ready  motor_mode[1:0], floor[1:0]
//   row      out  valid/ready  row_select_n[7:0], column_bits[7:0],
//                              row_index[2:0], frame_last
//   cfg      in   cfg_we       cfg_wdata[15:0] = shift period in ms
//
// A tick passes the input register and then the row output register; one tick per
// cycle is sustained through the two registers while the row output is not stalled.
// Glyph lookup, arrow rotation and period test sit between those registers.
// Reset (synchronous) restores the arrow images, counters and a 200 ms period.
// A stalled row output holds the input register; mode 3 ticks drain without
// waiting on the output.
// ----------------------------------------------------------------------------
module elevator_floor_arrow_matrix_scan_core (
  input  logic                              clk,
  input  logic                              rst,
  efams_tick_if.sink                        tick,
  efams_row_if.source                       row,
  input  logic                              cfg_we,
  input  logic [efams_pkg::PERIOD_W-1:0]    cfg_wdata
);
  import efams_pkg::*;

  item_t             item;
  logic              advance;
  logic              emit;
  logic              out_free;
  logic [TICK_W-1:0] tick_count;
  logic [ROW_W-1:0]  scan_row;
  logic [PERIOD_W-1:0] period;
  arrow_req_t        up_req;
  arrow_req_t        down_req;
  logic [7:0]        up_bits;
  logic [7:0]        down_bits;
  logic [7:0]        col;
  result_t           res;

  efams_in_reg u_in_reg (
    .clk     (clk),
    .rst     (rst),
    .tick    (tick),
    .advance (advance),
    .item    (item)
  );

  // A held tick moves on when the output has room, or at once if it shows nothing
  assign advance = item.valid && (item.mode == MODE_OTHER || out_free);
  assign emit    = advance && (item.mode != MODE_OTHER);

  // Period register
  always_ff @(posedge clk) begin
    if (rst) begin
      period <= PERIOD_RESET;
    end else if (cfg_we) begin
      period <= cfg_wdata;
    end
  end

  // Tick counter and scan position
  always_ff @(posedge clk) begin
    if (rst) begin
      tick_count <= '0;
      scan_row   <= '0;
    end else begin
      if (advance) begin
        tick_count <= tick_count + 1'b1;
      end
      if (emit) begin
        scan_row <= scan_row + 1'b1;
      end
    end
  end

  // Arrow stores
  assign up_req   = '{valid: advance && item.mode == MODE_UP,   row: scan_row, now: tick_count};
  assign down_req = '{valid: advance && item.mode == MODE_DOWN, row: scan_row, now: tick_count};

  efams_arrow_store #(.DIR(DIR_UP)) u_up_store (
    .clk    (clk),
    .rst    (rst),
    .req    (up_req),
    .period (period),
    .bits   (up_bits)
  );

  efams_arrow_store #(.DIR(DIR_DOWN)) u_down_store (
    .clk    (clk),
    .rst    (rst),
    .req    (down_req),
    .period (period),
    .bits   (down_bits)
  );

  // Column pattern by mode
  always_comb begin
    unique case (item.mode)
      MODE_IDLE: col = DIGIT_GLYPH[item.floor][scan_row];
      MODE_UP:   col = up_bits;
      MODE_DOWN: col = down_bits;
      default:   col = '0;
    endcase
  end

  assign res.row_select_n = ~(8'(1) << scan_row);
  assign res.column_bits  = col;
  assign res.row_index    = scan_row;
  assign res.frame_last   = (scan_row == ROW_W'(ROWS - 1));

  efams_out_reg u_out_reg (
    .clk  (clk),
    .rst  (rst),
    .load (emit),
    .res  (res),
    .free (out_free),
    .row  (row)
  );

  // Checks
  a_tick_counts: assert property (@(posedge clk) disable iff (rst)
    advance |=> tick_count == $past(tick_count) + 1'b1)
    else $error("tick counter missed a transaction");

  a_scan_hold: assert property (@(posedge clk) disable iff (rst)
    !emit |=> $stable(scan_row))
    else $error("scan row moved without an emitted row");

  a_emit_loads: assert property (@(posedge clk) disable iff (rst)
    emit |=> row.valid)
    else $error("emitted row not presented");

  a_frame_last: assert property (@(posedge clk) disable iff (rst)
    row.valid && row.frame_last |-> row.row_index == ROW_W'(ROWS - 1))
    else $error("frame_last on a row other than the last");

endmodule

FILE: rtl/efams_in_reg.sv
// ----------------------------------------------------------------------------
// efams_in_reg: tick input register
// Holds one accepted tick until the processing logic consumes it.
// ----------------------------------------------------------------------------
module efams_in_reg (
  input  logic            clk,
  input  logic            rst,
  efams_tick_if.sink      tick,
  input  logic            advance,
  output efams_pkg::item_t item
);
  import efams_pkg::*;

  item_t item_q;

  // Take a new tick whenever the register is empty or drains this cycle
  assign tick.ready = !item_q.valid || advance;
  assign item       = item_q;

  always_ff @(posedge clk) begin
    if (rst) begin
      item_q.valid <= 1'b0;
    end else if (tick.ready) begin
      item_q.valid <= tick.valid;
    end
    if (tick.ready && tick.valid) begin
      item_q.mode  <= mode_t'(tick.motor_mode);
      item_q.floor <= tick.floor;
    end
  end

endmodule

FILE: rtl/efams_arrow_store.sv
// ----------------------------------------------------------------------------
// efams_arrow_store: rotating arrow image
// Eight rows of one arrow, rotated one row at frame start once the period
// since the last rotation has elapsed.
// ----------------------------------------------------------------------------
module efams_arrow_store #(
  parameter efams_pkg::dir_t DIR = efams_pkg::DIR_UP
) (
  input  logic                                clk,
  input  logic                                rst,
  input  efams_pkg::arrow_req_t               req,
  input  logic [efams_pkg::PERIOD_W-1:0]      period,
  output logic [7:0]                          bits
);
  import efams_pkg::*;

  logic [7:0]        rows     [ROWS];
  logic [7:0]        rows_rot [ROWS];
  logic [7:0]        rows_eff [ROWS];
  logic [TICK_W-1:0] last_shift;
  logic [TICK_W-1:0] elapsed;
  logic              rotate;

  // Rotated image: up moves rows toward row 0, down toward row 7
  always_comb begin
    for (int i = 0; i < ROWS; i++) begin
      if (DIR == DIR_UP) begin
        rows_rot[i] = rows[ROW_W'(i + 1)];
      end else begin
        rows_rot[i] = rows[ROW_W'(i + ROWS - 1)];
      end
    end
  end

  // Period test, made only at frame start
  assign elapsed = req.now - last_shift;
  assign rotate  = req.valid && (req.row == '0) &&
                   (elapsed >= {{(TICK_W-PERIOD_W){1'b0}}, period});

  always_comb begin
    for (int i = 0; i < ROWS; i++) begin
      rows_eff[i] = rotate ? rows_rot[i] : rows[i];
    end
  end

  assign bits = rows_eff[req.row];

  always_ff @(posedge clk) begin
    if (rst) begin
      last_shift <= '0;
      for (int i = 0; i < ROWS; i++) begin
        rows[i] <= (DIR == DIR_UP) ? UP_GLYPH[i] : DOWN_GLYPH[i];
      end
    end else if (rotate) begin
      last_shift <= req.now;
      for (int i = 0; i < ROWS; i++) begin
        rows[i] <= rows_rot[i];
      end
    end
  end

endmodule

FILE: rtl/efams_out_reg.sv
// ----------------------------------------------------------------------------
// efams_out_reg: scanned-row output register
// Holds one result until the sink takes it; frees in the same cycle.
// ----------------------------------------------------------------------------
module efams_out_reg (
  input  logic              clk,
  input  logic              rst,
  input  logic              load,
  input  efams_pkg::result_t res,
  output logic              free,
  efams_row_if.source       row
);
  import efams_pkg::*;

  logic    valid;
  result_t data;

  assign free = !valid || row.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (load) begin
      valid <= 1'b1;
    end else if (row.ready) begin
      valid <= 1'b0;
    end
    if (load) begin
      data <= res;
    end
  end

  assign row.valid        = valid;
  assign row.row_select_n = data.row_select_n;
  assign row.column_bits  = data.column_bits;
  assign row.row_index    = data.row_index;
  assign row.frame_last   = data.frame_last;

endmodule

FILE: tb/elevator_floor_arrow_matrix_scan_core_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// elevator_floor_arrow_matrix_scan_core_tb: self-checking bench for the scan core
// Drives millisecond ticks with random bursts and gaps, stalls the row output
// on its own pattern and checks every scanned row against an in-bench model
// of the digit glyphs, the rotating arrows and the row counter. The shift
// period is swept through zero, one, small values, the reset value and the
// maximum, and one long output hold-off fills the core so it stalls its input.
// ----------------------------------------------------------------------------
module elevator_floor_arrow_matrix_scan_core_tb;
  import efams_pkg::*;

  localparam int MAX_REPORTS = 40;
  localparam int DRAIN_LIMIT = 4000;
  localparam int HOLD_CYCLES = 150;

  // Expected glyph images, row 0 first
  localparam logic [7:0] NUMERAL_ROWS [4][8] = '{
    '{8'h18, 8'h38, 8'h18, 8'h18, 8'h18, 8'h18, 8'h7E, 8'h7E},
    '{8'h70, 8'h88, 8'h08, 8'h10, 8'h20, 8'h40, 8'hF8, 8'h06},
    '{8'hF8, 8'h10, 8'h20, 8'h10, 8'h08, 8'h88, 8'h70, 8'h06},
    '{8'h10, 8'h30, 8'h50, 8'h90, 8'hF8, 8'h10, 8'h10, 8'h06}
  };
  localparam logic [7:0] ARROW_UP_ROWS [8] =
    '{8'h10, 8'h28, 8'h44, 8'hEE, 8'h28, 8'h28, 8'h38, 8'h28};
  localparam logic [7:0] ARROW_DOWN_ROWS [8] =
    '{8'h28, 8'h38, 8'h28, 8'h28, 8'hEE, 8'h44, 8'h28, 8'h10};

  logic                clk = 1'b0;
  logic                rst;
  logic                cfg_we;
  logic [PERIOD_W-1:0] cfg_wdata;

  efams_tick_if tick_ch ();
  efams_row_if  row_ch ();

  elevator_floor_arrow_matrix_scan_core dut (
    .clk       (clk),
    .rst       (rst),
    .tick      (tick_ch),
    .row       (row_ch),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  // Model state
  logic [PERIOD_W-1:0] rotate_period;
  logic [TICK_W-1:0]   ms_ticks;
  logic [TICK_W-1:0]   up_rotated_at;
  logic [TICK_W-1:0]   down_rotated_at;
  logic [7:0]          up_image [8];
  logic [7:0]          down_image [8];
  logic [ROW_W-1:0]    next_row;

  result_t expected_rows [$];
  int      mismatches = 0;
  int      burst_left = 0;
  bit      hold_req = 1'b0;

  // Clock: 10 ns period
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  task automatic report_mismatch(input string msg);
    mismatches++;
    if (mismatches <= MAX_REPORTS)
      $display("%0t ns: mismatch: %s", $realtime, msg);
  endtask

  // Model of one tick; queues the row it shows, if any
  task automatic predict_scanned_row(input mode_t m, input logic [1:0] fl);
    logic [TICK_W-1:0] now;
    logic [7:0]        bits;
    logic [7:0]        keep;
    result_t           r;
    now      = ms_ticks;
    ms_ticks = ms_ticks + 1;
    case (m)
      MODE_IDLE: begin
        bits = NUMERAL_ROWS[fl][next_row];
      end
      MODE_UP: begin
        if (next_row == 0 && (now - up_rotated_at) >= {16'd0, rotate_period}) begin
          up_rotated_at = now;
          keep = up_image[0];
          for (int i = 0; i < 7; i++) up_image[i] = up_image[i+1];
          up_image[7] = keep;
        end
        bits = up_image[next_row];
      end
      MODE_DOWN: begin
        if (next_row == 0 && (now - down_rotated_at) >= {16'd0, rotate_period}) begin
          down_rotated_at = now;
          keep = down_image[7];
          for (int i = 7; i > 0; i--) down_image[i] = down_image[i-1];
          down_image[0] = keep;
        end
        bits = down_image[next_row];
      end
      default: return;
    endcase
    r.row_select_n = ~(8'd1 << next_row);
    r.column_bits  = bits;
    r.row_index    = next_row;
    r.frame_last   = (next_row == 3'd7);
    expected_rows.push_back(r);
    next_row = next_row + 3'd1;
  endtask

  // Tick monitor: every accepted transaction goes through the model
  always @(posedge clk) begin
    if (!rst && tick_ch.valid && tick_ch.ready)
      predict_scanned_row(mode_t'(tick_ch.motor_mode), tick_ch.floor);
  end

  // Row checker
  always @(posedge clk) begin
    result_t want;
    if (!rst && row_ch.valid && row_ch.ready) begin
      if (expected_rows.size() == 0) begin
        report_mismatch($sformatf("row %0d shown with nothing expected", row_ch.row_index));
      end else begin
        want = expected_rows.pop_front();
        if (row_ch.row_select_n !== want.row_select_n)
          report_mismatch($sformatf("row_select_n got %02h want %02h",
                                    row_ch.row_select_n, want.row_select_n));
        if (row_ch.column_bits !== want.column_bits)
          report_mismatch($sformatf("column_bits got %02h want %02h (row %0d)",
                                    row_ch.column_bits, want.column_bits, want.row_index));
        if (row_ch.row_index !== want.row_index)
          report_mismatch($sformatf("row_index got %0d want %0d",
                                    row_ch.row_index, want.row_index));
        if (row_ch.frame_last !== want.frame_last)
          report_mismatch($sformatf("frame_last got %0b want %0b (row %0d)",
                                    row_ch.frame_last, want.frame_last, want.row_index));
      end
    end
  end

  // Output stall pattern: phases of varying stall rate, plus a requested hold-off
  always @(posedge clk) begin
    int stall_pct;
    int phase_left;
    int hold_left;
    bit hold_taken;
    if (rst) begin
      row_ch.ready <= 1'b0;
      phase_left = 0;
      hold_left  = 0;
    end else begin
      if (hold_req && !hold_taken) begin
        hold_left  = HOLD_CYCLES;
        hold_taken = 1'b1;
      end
      if (phase_left == 0) begin
        phase_left = $urandom_range(16, 96);
        case ($urandom_range(0, 3))
          0:       stall_pct = 0;
          1:       stall_pct = 20;
          2:       stall_pct = 50;
          default: stall_pct = 85;
        endcase
      end
      phase_left--;
      if (hold_left > 0) begin
        hold_left--;
        row_ch.ready <= 1'b0;
      end else begin
        row_ch.ready <= ($urandom_range(0, 99) >= stall_pct);
      end
    end
  end

  // One tick transaction, with the burst/gap pattern of the sender
  task automatic send_tick(input mode_t m, input logic [1:0] fl);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      repeat (gap) begin
        tick_ch.valid <= 1'b0;
        @(posedge clk);
      end
      burst_left = $urandom_range(1, 20);
    end
    tick_ch.valid      <= 1'b1;
    tick_ch.motor_mode <= m;
    tick_ch.floor      <= fl;
    @(posedge clk);
    while (!tick_ch.ready) @(posedge clk);
    burst_left--;
  endtask

  // Stop sending and wait for every expected row, then let mode 3 ticks drain
  task automatic settle_idle();
    int waited;
    tick_ch.valid <= 1'b0;
    waited = 0;
    // the last accepted transaction reaches the model at this edge
    @(posedge clk);
    while (expected_rows.size() != 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk);
      waited++;
    end
    repeat (4) @(posedge clk);
  endtask

  task automatic write_period(input logic [PERIOD_W-1:0] value);
    settle_idle();
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we        <= 1'b0;
    rotate_period  = value;
  endtask

  // Random traffic: mostly whole frames of one mode, some cut short, some mode 3
  task automatic run_traffic(input int n_items);
    int    shown;
    int    run;
    int    pick;
    mode_t m;
    logic [1:0] fl;
    shown = 0;
    while (shown < n_items) begin
      pick = $urandom_range(0, 99);
      if (pick < 35)      m = MODE_UP;
      else if (pick < 70) m = MODE_DOWN;
      else if (pick < 90) m = MODE_IDLE;
      else                m = MODE_OTHER;
      if (m == MODE_OTHER)
        run = $urandom_range(1, 3);
      else if ($urandom_range(0, 3) == 0)
        run = $urandom_range(1, 7);
      else
        run = 8 * $urandom_range(1, 3);
      fl = 2'($urandom_range(0, 3));
      repeat (run) begin
        if ($urandom_range(0, 7) == 0) fl = 2'($urandom_range(0, 3));
        send_tick(m, fl);
        if (m != MODE_OTHER) shown++;
      end
    end
  endtask

  // Digits of every floor, mode 3 mid-frame and mode changes within a frame
  task automatic test_directed();
    for (int i = 0; i < 8; i++) send_tick(MODE_IDLE, i[1:0]);
    send_tick(MODE_IDLE, 2'd1);
    send_tick(MODE_OTHER, 2'd3);
    send_tick(MODE_OTHER, 2'd0);
    send_tick(MODE_IDLE, 2'd2);
    for (int i = 0; i < 8; i++) send_tick(i[0] ? MODE_DOWN : MODE_UP, 2'd3);
    send_tick(MODE_UP, 2'd0);
    send_tick(MODE_OTHER, 2'd2);
    send_tick(MODE_DOWN, 2'd1);
    send_tick(MODE_IDLE, 2'd3);
    settle_idle();
  endtask

  // Zero period: arrows rotate at every frame start
  task automatic test_period_zero();
    write_period('0);
    run_traffic(60);
    settle_idle();
  endtask

  task automatic test_period_one();
    write_period(16'd1);
    run_traffic(60);
    settle_idle();
  endtask

  task automatic test_period_small();
    write_period(16'($urandom_range(2, 12)));
    run_traffic(60);
    write_period(16'($urandom_range(13, 60)));
    run_traffic(60);
    settle_idle();
  endtask

  // Maximum period: no further rotation within this run
  task automatic test_period_max();
    write_period('1);
    run_traffic(40);
    settle_idle();
  endtask

  task automatic test_period_reset_value();
    write_period(PERIOD_RESET);
    run_traffic(80);
    settle_idle();
  endtask

  // Long output hold-off while ticks keep coming, so the core backs up
  task automatic test_output_hold();
    write_period(16'd8);
    hold_req = 1'b1;
    repeat (48) send_tick(mode_t'($urandom_range(0, 2)), 2'($urandom_range(0, 3)));
    settle_idle();
  endtask

  initial begin
    rst                = 1'b1;
    cfg_we             = 1'b0;
    cfg_wdata          = '0;
    tick_ch.valid      = 1'b0;
    tick_ch.motor_mode = MODE_IDLE;
    tick_ch.floor      = 2'd0;

    // Model reset
    rotate_period   = PERIOD_RESET;
    ms_ticks        = '0;
    up_rotated_at   = '0;
    down_rotated_at = '0;
    next_row        = '0;
    for (int i = 0; i < 8; i++) begin
      up_image[i]   = ARROW_UP_ROWS[i];
      down_image[i] = ARROW_DOWN_ROWS[i];
    end

    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_directed();
    test_period_zero();
    test_period_one();
    test_period_small();
    test_period_max();
    test_output_hold();
    test_period_reset_value();

    settle_idle();
    if (expected_rows.size() != 0)
      report_mismatch($sformatf("%0d rows never shown", expected_rows.size()));
    if (mismatches == 0) $display("RESULT: OK");
    else $display("RESULT: ERROR");
    $finish;
  end

  // Run limit
  initial begin
    #2_000_000;
    $display("RESULT: ERROR");
    $finish;
  end

endmodule

FILE: filelist.f
rtl/efams_pkg.sv
rtl/efams_if.sv
rtl/efams_in_reg.sv
rtl/efams_arrow_store.sv
rtl/efams_out_reg.sv
rtl/elevator_floor_arrow_matrix_scan_core.sv
tb/elevator_floor_arrow_matrix_scan_core_tb.sv
